// ----- sv/rfd_pkg.sv -----
// Shared types and constants for the remote frame decoder.
// Used by rfd_unpack, rfd_shooter and the top level; depends on nothing.
package rfd_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int LAST_BYTE   = FRAME_BYTES - 1;

  localparam logic [7:0]  HOLD_FRAMES_RST = 8'd50;
  localparam logic [10:0] STICK_MASK      = 11'h7FF;
  // Minus 1024 in 12-bit two's complement.
  localparam logic [11:0] STICK_OFFSET    = 12'hC00;
  localparam logic [7:0]  BUTTON_PRESSED  = 8'd1;

  typedef logic [7:0] byte_t;
  typedef byte_t [FRAME_BYTES-1:0] frame_t;

  // Fields unpacked from one complete frame.
  typedef struct packed {
    logic [3:0][11:0] stick;
    logic [1:0]       s1;
    logic [1:0]       s2;
    logic [15:0]      mouse_dx;
    logic [15:0]      mouse_dy;
    logic [15:0]      key_bits;
    byte_t            mouse_left;
    byte_t            mouse_right;
  } fields_t;

  // Inputs to the shooter control for one frame.
  typedef struct packed {
    logic       ramp_done;
    logic [1:0] s1;
    logic [1:0] s2;
    byte_t      mouse_left;
    byte_t      mouse_right;
  } shoot_in_t;

  // Control state after the frame has been applied.
  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] friction;
    logic       feeder;
  } shoot_out_t;

endpackage

// ----- sv/rfd_unpack.sv -----
// Unpacks stick channels, switches, mouse and keys from a 16-byte frame.
// Depends on rfd_pkg.
module rfd_unpack (
  input  rfd_pkg::frame_t  frame,
  output rfd_pkg::fields_t fields
);

  logic [10:0] ch0, ch1, ch2, ch3;
  logic        all_nonzero;

  assign ch0 = {frame[1][2:0], frame[0]} & rfd_pkg::STICK_MASK;
  assign ch1 = {frame[2][5:0], frame[1][7:3]};
  assign ch2 = {frame[4][0], frame[3], frame[2][7:6]};
  assign ch3 = {frame[5][3:0], frame[4][7:1]};

  // Centering is applied only when every channel reports a nonzero value.
  assign all_nonzero = (ch0 != '0) && (ch1 != '0) && (ch2 != '0) && (ch3 != '0);

  always_comb begin
    fields.stick[0] = {1'b0, ch0};
    fields.stick[1] = {1'b0, ch1};
    fields.stick[2] = {1'b0, ch2};
    fields.stick[3] = {1'b0, ch3};
    if (all_nonzero) begin
      fields.stick[0] = {1'b0, ch0} + rfd_pkg::STICK_OFFSET;
      fields.stick[1] = {1'b0, ch1} + rfd_pkg::STICK_OFFSET;
      fields.stick[2] = {1'b0, ch2} + rfd_pkg::STICK_OFFSET;
      fields.stick[3] = {1'b0, ch3} + rfd_pkg::STICK_OFFSET;
    end
    fields.s1          = frame[5][5:4];
    fields.s2          = frame[5][7:6];
    fields.mouse_dx    = {frame[7], frame[6]};
    fields.mouse_dy    = {frame[9], frame[8]};
    fields.key_bits    = {frame[15], frame[14]};
    fields.mouse_left  = frame[12];
    fields.mouse_right = frame[13];
  end

endmodule

// ----- sv/rfd_shooter.sv -----
// Mode selection and friction/feeder control, advanced once per frame.
// Depends on rfd_pkg. The next-state values are handed to the result register.
module rfd_shooter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [7:0]            hold_frames,
  input  rfd_pkg::shoot_in_t    sin,
  output rfd_pkg::shoot_out_t   sout
);

  typedef enum logic [1:0] {
    MODE_PREPARE  = 2'd0,
    MODE_REMOTE   = 2'd1,
    MODE_STOP     = 2'd2,
    MODE_KEYBOARD = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FRI_OFF  = 2'd0,
    FRI_WAIT = 2'd1,
    FRI_ON   = 2'd2
  } fri_t;

  mode_t      mode_r, mode_nxt;
  fri_t       fri_r, fri_nxt;
  logic       feeder_r, feeder_nxt;
  logic [8:0] cnt_r, cnt_nxt;
  logic       lock_r, lock_nxt;
  logic [7:0] prev_right_r, prev_right_nxt;
  logic [1:0] prev_s2_r, prev_s2_nxt;

  logic [8:0] cnt_inc, cnt_tmp;
  logic       lock_tmp;
  logic       r_one, r_zero, l_one, s2_down2, s2_up;

  assign cnt_inc  = cnt_r + 9'd1;
  assign r_one    = (sin.mouse_right == rfd_pkg::BUTTON_PRESSED);
  assign r_zero   = (sin.mouse_right == 8'd0);
  assign l_one    = (sin.mouse_left == rfd_pkg::BUTTON_PRESSED);
  assign s2_down2 = ({1'b0, sin.s2} + 3'd2) == {1'b0, prev_s2_r};
  assign s2_up    = {1'b0, sin.s2} == ({1'b0, prev_s2_r} + 3'd1);

  always_comb begin
    mode_nxt       = mode_r;
    fri_nxt        = fri_r;
    feeder_nxt     = feeder_r;
    cnt_nxt        = cnt_r;
    lock_nxt       = lock_r;
    prev_right_nxt = prev_right_r;
    prev_s2_nxt    = prev_s2_r;
    cnt_tmp        = '0;
    lock_tmp       = lock_r;
    if (step_en) begin
      if (!sin.ramp_done) begin
        mode_nxt = MODE_PREPARE;
      end else begin
        unique case (sin.s1)
          2'd1:    mode_nxt = MODE_REMOTE;
          2'd2:    mode_nxt = MODE_STOP;
          2'd3:    mode_nxt = MODE_KEYBOARD;
          default: mode_nxt = mode_r;
        endcase
      end

      if (mode_nxt == MODE_REMOTE) begin
        prev_s2_nxt = sin.s2;
        // A drop of two switch positions toggles the friction wheels.
        if (s2_down2) begin
          unique case (fri_r)
            FRI_OFF: fri_nxt = FRI_ON;
            FRI_ON:  fri_nxt = FRI_OFF;
            default: fri_nxt = fri_r;
          endcase
        end
        if (fri_nxt == FRI_ON && prev_s2_r == 2'd3 && sin.s2 == 2'd2) begin
          feeder_nxt = 1'b1;
        end
        if (feeder_nxt && s2_up) begin
          feeder_nxt = 1'b0;
        end
      end else if (mode_nxt == MODE_KEYBOARD) begin
        prev_right_nxt = sin.mouse_right;
        unique case (fri_r)
          FRI_OFF: begin
            feeder_nxt = 1'b0;
            if (prev_right_r == 8'd0 && r_one) begin
              fri_nxt = FRI_WAIT;
            end
          end
          FRI_WAIT: begin
            cnt_tmp = r_one ? cnt_inc : 9'd0;
            if (cnt_tmp == {1'b0, hold_frames}) begin
              lock_nxt = 1'b1;
              cnt_nxt  = '0;
              fri_nxt  = FRI_ON;
            end else begin
              cnt_nxt = cnt_tmp;
            end
          end
          FRI_ON: begin
            // Releasing the right button frees the lock taken on arming.
            if (prev_right_r == rfd_pkg::BUTTON_PRESSED && r_zero) begin
              lock_tmp = 1'b0;
            end
            cnt_tmp  = (r_one && !lock_tmp) ? cnt_inc : 9'd0;
            lock_nxt = lock_tmp;
            if (cnt_tmp > {1'b0, hold_frames}) begin
              cnt_nxt = '0;
              fri_nxt = FRI_OFF;
            end else begin
              cnt_nxt = cnt_tmp;
            end
            feeder_nxt = l_one;
          end
          default: fri_nxt = fri_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_PREPARE;
      fri_r        <= FRI_OFF;
      feeder_r     <= 1'b0;
      cnt_r        <= '0;
      lock_r       <= 1'b0;
      prev_right_r <= '0;
      prev_s2_r    <= '0;
    end else begin
      mode_r       <= mode_nxt;
      fri_r        <= fri_nxt;
      feeder_r     <= feeder_nxt;
      cnt_r        <= cnt_nxt;
      lock_r       <= lock_nxt;
      prev_right_r <= prev_right_nxt;
      prev_s2_r    <= prev_s2_nxt;
    end
  end

  assign sout.mode     = mode_nxt;
  assign sout.friction = fri_nxt;
  assign sout.feeder   = feeder_nxt;

  a_state_holds_without_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(mode_r) && $stable(fri_r) && $stable(cnt_r) && $stable(lock_r))
    else $error("shooter state changed without a frame");

  a_ramp_forces_prepare: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !sin.ramp_done |=> mode_r == MODE_PREPARE)
    else $error("mode not prepare after frame with ramp not done");

  a_arm_takes_lock: assert property (@(posedge clk) disable iff (!rst_n)
    fri_r == FRI_ON && $past(fri_r) == FRI_WAIT && $past(rst_n) |-> lock_r && cnt_r == '0)
    else $error("arming friction did not take the hold lock");

endmodule

// ----- sv/remote_frame_decoder_with_shooter_fsm_top.sv -----
// Top level of the remote frame decoder with shooter control.
// Depends on rfd_pkg, rfd_unpack and rfd_shooter.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    data_byte, byte_index, ramp_done
//   out_     output     out_valid / out_ready  sticks, switches, mouse, keys, mode, ...
//   cfg_     input      cfg_valid / cfg_ready  hold_frames
//
// One byte per cycle while in_ready is high; a result appears the cycle after byte 15.
// Bytes with positions 0 to 14 and 16 and up produce no result and are never stalled
// unless the result register is full and not being drained.
// in_ready is low only while a result waits and out_ready is low.
// Synchronous reset clears the frame store, the control state and hold_frames to 50.
// cfg_ready is always high.
module remote_frame_decoder_with_shooter_fsm_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic [4:0]         in_byte_index,
  input  logic               in_ramp_done,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [11:0] out_stick_ch0,
  output logic signed [11:0] out_stick_ch1,
  output logic signed [11:0] out_stick_ch2,
  output logic signed [11:0] out_stick_ch3,
  output logic [1:0]         out_switch_one,
  output logic [1:0]         out_switch_two,
  output logic signed [15:0] out_mouse_dx,
  output logic signed [15:0] out_mouse_dy,
  output logic [15:0]        out_key_bits,
  output logic [1:0]         out_mode,
  output logic [1:0]         out_friction,
  output logic               out_feeder,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_hold_frames
);

  rfd_pkg::frame_t     store_r;
  rfd_pkg::frame_t     frame_view;
  rfd_pkg::fields_t    fields;
  rfd_pkg::shoot_in_t  sin;
  rfd_pkg::shoot_out_t sout;

  logic [7:0] hold_frames_r;
  logic       in_fire, store_en, step_en;

  logic             out_valid_r;
  logic [3:0][11:0] stick_r;
  logic [1:0]       s1_r, s2_r;
  logic [15:0]      dx_r, dy_r, keys_r;
  rfd_pkg::shoot_out_t status_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign store_en  = in_fire && !in_byte_index[4];
  assign step_en   = in_fire && (in_byte_index == 5'(rfd_pkg::LAST_BYTE));

  // The last byte is decoded in the cycle it arrives, alongside the stored ones.
  always_comb begin
    frame_view = store_r;
    frame_view[rfd_pkg::LAST_BYTE] = in_data_byte;
  end

  rfd_unpack u_unpack (
    .frame  (frame_view),
    .fields (fields)
  );

  assign sin.ramp_done   = in_ramp_done;
  assign sin.s1          = fields.s1;
  assign sin.s2          = fields.s2;
  assign sin.mouse_left  = fields.mouse_left;
  assign sin.mouse_right = fields.mouse_right;

  rfd_shooter u_shooter (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .hold_frames (hold_frames_r),
    .sin         (sin),
    .sout        (sout)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r       <= '0;
      hold_frames_r <= rfd_pkg::HOLD_FRAMES_RST;
      out_valid_r   <= 1'b0;
    end else begin
      if (store_en) begin
        store_r[in_byte_index[3:0]] <= in_data_byte;
      end
      if (cfg_valid && cfg_ready) begin
        hold_frames_r <= cfg_hold_frames;
      end
      if (step_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      stick_r  <= fields.stick;
      s1_r     <= fields.s1;
      s2_r     <= fields.s2;
      dx_r     <= fields.mouse_dx;
      dy_r     <= fields.mouse_dy;
      keys_r   <= fields.key_bits;
      status_r <= sout;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_stick_ch0  = stick_r[0];
  assign out_stick_ch1  = stick_r[1];
  assign out_stick_ch2  = stick_r[2];
  assign out_stick_ch3  = stick_r[3];
  assign out_switch_one = s1_r;
  assign out_switch_two = s2_r;
  assign out_mouse_dx   = dx_r;
  assign out_mouse_dy   = dy_r;
  assign out_key_bits   = keys_r;
  assign out_mode       = status_r.mode;
  assign out_friction   = status_r.friction;
  assign out_feeder     = status_r.feeder;

endmodule
